FILE: rtl/pwm_speed_regulator_top_macros.svh
// Assertion macros used by the checker file.
`ifndef PWM_SPEED_REGULATOR_TOP_MACROS_SVH
`define PWM_SPEED_REGULATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PSR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("psr check failed");

// Next-cycle implication, disabled while in reset.
`define PSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("psr check failed");

// Delayed implication, disabled while in reset.
`define PSR_ASSERT_LATER(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##2 (cons)) \
		else $error("psr check failed");

`endif

FILE: rtl/psr_pkg.sv
// ----------------------------------------------------------------------------
// psr_pkg
// Types and constants shared by the PWM speed regulator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package psr_pkg;

	localparam int unsigned TimeW  = 14;
	localparam int unsigned SpeedW = 12;
	localparam int unsigned CountW = 16;
	localparam int unsigned IdxW   = 3;

	// Opcodes
	localparam logic [1:0] OP_EXPIRY   = 2'd0;
	localparam logic [1:0] OP_COUNT    = 2'd1;
	localparam logic [1:0] OP_OVERFLOW = 2'd2;

	// Adjust codes
	localparam logic [1:0] ADJ_KEEP = 2'd0;
	localparam logic [1:0] ADJ_UP   = 2'd1;
	localparam logic [1:0] ADJ_DOWN = 2'd2;

	// Register indexes
	localparam logic [IdxW-1:0] REG_TARGET   = 3'd0;
	localparam logic [IdxW-1:0] REG_DEADBAND = 3'd1;
	localparam logic [IdxW-1:0] REG_GAIN     = 3'd2;
	localparam logic [IdxW-1:0] REG_DUTY_MIN = 3'd3;
	localparam logic [IdxW-1:0] REG_DUTY_MAX = 3'd4;
	localparam logic [IdxW-1:0] REG_WINDOW   = 3'd5;

	// Reset values
	localparam logic [7:0]        RST_TARGET   = 8'd0;
	localparam logic [7:0]        RST_DEADBAND = 8'd5;
	localparam logic [2:0]        RST_GAIN     = 3'd2;
	localparam logic [TimeW-1:0]  RST_DUTY_MIN = 14'd100;
	localparam logic [TimeW-1:0]  RST_DUTY_MAX = 14'd9900;
	localparam logic [7:0]        RST_WINDOW   = 8'd20;
	localparam logic [TimeW-1:0]  RST_HALF     = 14'd5000;

	localparam logic [SpeedW-1:0] SPEED_MAX = 12'hFFF;
	localparam logic [TimeW-1:0]  TIME_MAX  = 14'h3FFF;
	localparam logic [7:0]        STEP_MAX  = 8'hFF;

	typedef struct packed {
		logic [7:0]       target_speed;
		logic [7:0]       dead_band;
		logic [2:0]       gain_shift;
		logic [TimeW-1:0] duty_min_time;
		logic [TimeW-1:0] duty_max_time;
		logic [7:0]       window_toggles;
	} cfg_t;

	typedef struct packed {
		logic              pwm_level;
		logic [TimeW-1:0]  interval_us;
		logic              window_end;
		logic [SpeedW-1:0] speed_now;
		logic [1:0]        adjust;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/psr_cfg_regs.sv
// ----------------------------------------------------------------------------
// psr_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module psr_cfg_regs (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [psr_pkg::IdxW-1:0] cfg_index,
	input  wire logic [psr_pkg::TimeW-1:0] cfg_wr_data,
	output psr_pkg::cfg_t                 cfg
);
	import psr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_speed   <= RST_TARGET;
			cfg_q.dead_band      <= RST_DEADBAND;
			cfg_q.gain_shift     <= RST_GAIN;
			cfg_q.duty_min_time  <= RST_DUTY_MIN;
			cfg_q.duty_max_time  <= RST_DUTY_MAX;
			cfg_q.window_toggles <= RST_WINDOW;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TARGET:   cfg_q.target_speed   <= cfg_wr_data[7:0];
				REG_DEADBAND: cfg_q.dead_band      <= cfg_wr_data[7:0];
				REG_GAIN:     cfg_q.gain_shift     <= cfg_wr_data[2:0];
				REG_DUTY_MIN: cfg_q.duty_min_time  <= cfg_wr_data;
				REG_DUTY_MAX: cfg_q.duty_max_time  <= cfg_wr_data;
				REG_WINDOW:   cfg_q.window_toggles <= cfg_wr_data[7:0];
				default: ; // unmapped index, ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/psr_core.sv
// ----------------------------------------------------------------------------
// psr_core
// Regulator state and the single-pass update for one registered event.
// ----------------------------------------------------------------------------
`default_nettype none

module psr_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       update,
	input  wire logic [1:0]                 opcode_s1,
	input  wire logic [psr_pkg::CountW-1:0] pulse_count_s1,
	input  wire psr_pkg::cfg_t              cfg,
	output psr_pkg::res_t                   res
);
	import psr_pkg::*;

	logic [TimeW-1:0]  high_q, low_q;
	logic              level_q;
	logic [7:0]        toggles_q;
	logic [SpeedW-1:0] speed_q;

	logic [TimeW-1:0]  high_nxt, low_nxt;
	logic              level_nxt;
	logic [7:0]        toggles_nxt;
	logic [SpeedW-1:0] speed_nxt;

	// count * 10 / 4 == (count * 5) >> 1
	logic [CountW+2:0] cnt_x5;
	logic [CountW+1:0] cnt_half;
	logic [SpeedW-1:0] speed_meas;

	logic signed [SpeedW:0] err, db_pos, db_neg;
	logic [SpeedW-1:0]      err_abs;
	logic [SpeedW-1:0]      mag_shift;
	logic [7:0]             step;

	logic [TimeW:0] up_lim, low_add, high_add;
	logic [7:0]     toggles_inc;
	logic           wend;
	logic [1:0]     adj;

	always_comb begin
		cnt_x5     = {1'b0, pulse_count_s1, 2'b00} + {3'b000, pulse_count_s1};
		cnt_half   = cnt_x5[CountW+2:1];
		speed_meas = (|cnt_half[CountW+1:SpeedW]) ? SPEED_MAX : cnt_half[SpeedW-1:0];

		err     = $signed({5'b0, cfg.target_speed}) - $signed({1'b0, speed_q});
		db_pos  = $signed({5'b0, cfg.dead_band});
		db_neg  = -db_pos;
		// magnitude never exceeds the speed range
		err_abs = err[SpeedW] ? 12'(-err) : 12'(err);
		mag_shift = err_abs >> cfg.gain_shift;
		step    = (|mag_shift[SpeedW-1:8]) ? STEP_MAX : mag_shift[7:0];

		up_lim   = {1'b0, cfg.duty_min_time} + {7'b0, step};
		low_add  = {1'b0, low_q} + {7'b0, step};
		high_add = {1'b0, high_q} + {7'b0, step};

		toggles_inc = toggles_q + 8'd1;
		wend        = (toggles_inc == cfg.window_toggles);

		high_nxt    = high_q;
		low_nxt     = low_q;
		level_nxt   = level_q;
		toggles_nxt = toggles_q;
		speed_nxt   = speed_q;
		adj         = ADJ_KEEP;

		unique case (opcode_s1)
			OP_COUNT:    speed_nxt = speed_meas;
			OP_OVERFLOW: speed_nxt = '0;
			OP_EXPIRY: begin
				toggles_nxt = wend ? 8'd0 : toggles_inc;
				if (err > db_pos) begin
					adj = ADJ_UP;
					if ({1'b0, high_q} > up_lim) begin
						high_nxt = high_q - {6'b0, step};
						low_nxt  = low_add[TimeW] ? TIME_MAX : low_add[TimeW-1:0];
					end else begin
						high_nxt = cfg.duty_min_time;
						low_nxt  = cfg.duty_max_time;
					end
				end else if (err < db_neg) begin
					adj = ADJ_DOWN;
					if (high_add < {1'b0, cfg.duty_max_time}) begin
						high_nxt = high_add[TimeW-1:0];
						low_nxt  = (low_q > {6'b0, step}) ? low_q - {6'b0, step} : '0;
					end else begin
						high_nxt = cfg.duty_max_time;
						low_nxt  = cfg.duty_min_time;
					end
				end
				level_nxt = ~level_q;
			end
			default: ; // spare opcode, no change
		endcase

		res.pwm_level   = level_nxt;
		res.interval_us = (opcode_s1 == OP_EXPIRY) ? (level_nxt ? high_nxt : low_nxt) : '0;
		res.window_end  = (opcode_s1 == OP_EXPIRY) && wend;
		res.speed_now   = speed_nxt;
		res.adjust      = adj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q    <= RST_HALF;
			low_q     <= RST_HALF;
			level_q   <= 1'b0;
			toggles_q <= '0;
			speed_q   <= '0;
		end else if (update) begin
			high_q    <= high_nxt;
			low_q     <= low_nxt;
			level_q   <= level_nxt;
			toggles_q <= toggles_nxt;
			speed_q   <= speed_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pwm_speed_regulator_top.sv
// An accepted request moves from the input register to the result register,
// held back only while an earlier result is still waiting to be taken.
// Throughput: one request per cycle; the input register and the result
// register each hold one request, so input stalls only when both are full.
// State and control registers clear on arst_n (asynchronous, active low);
// duty times reset to 5000 us each, level and window count to zero.
// ----------------------------------------------------------------------------
// pwm_speed_regulator_top
// Proportional PWM speed regulator with dead band, two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_speed_regulator_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [psr_pkg::IdxW-1:0]    cfg_index,
	input  wire logic [psr_pkg::TimeW-1:0]   cfg_wr_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  opcode,
	input  wire logic [psr_pkg::CountW-1:0]  pulse_count,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             pwm_level,
	output logic [psr_pkg::TimeW-1:0]        interval_us,
	output logic                             window_end,
	output logic [psr_pkg::SpeedW-1:0]       speed_now,
	output logic [1:0]                       adjust
);
	import psr_pkg::*;

	cfg_t cfg;
	res_t res;

	logic              valid_s1;
	logic [1:0]        opcode_s1;
	logic [CountW-1:0] pulse_count_s1;
	logic              valid_s2;
	res_t              res_s2;
	logic              advance;

	// stage 1 moves on when the result register is free or being emptied
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	psr_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.cfg         (cfg)
	);

	psr_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.update         (advance),
		.opcode_s1      (opcode_s1),
		.pulse_count_s1 (pulse_count_s1),
		.cfg            (cfg),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opcode_s1      <= opcode;
			pulse_count_s1 <= pulse_count;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign pwm_level   = res_s2.pwm_level;
	assign interval_us = res_s2.interval_us;
	assign window_end  = res_s2.window_end;
	assign speed_now   = res_s2.speed_now;
	assign adjust      = res_s2.adjust;

endmodule

`default_nettype wire

FILE: rtl/psr_checker.sv
// ----------------------------------------------------------------------------
// psr_checker
// Port-level checks on the regulator handshake and pipeline timing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pwm_speed_regulator_top_macros.svh"

module psr_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic                       pwm_level,
	input wire logic [psr_pkg::TimeW-1:0]  interval_us,
	input wire logic                       window_end,
	input wire logic [psr_pkg::SpeedW-1:0] speed_now,
	input wire logic [1:0]                 adjust
);
	import psr_pkg::*;

	// a stalled result holds
	`PSR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable({pwm_level, interval_us, window_end, speed_now, adjust}))

	// input only backs up behind a stalled result
	`PSR_ASSERT_NOW(a_backpressure, clk, arst_n, !in_ready, out_valid && !out_ready)

	// an accepted request reaches the output through the input and result registers
	`PSR_ASSERT_LATER(a_latency, clk, arst_n, in_valid && in_ready, out_valid)

	// spare adjust code never shows
	`PSR_ASSERT_NOW(a_adjust_code, clk, arst_n, out_valid, adjust == ADJ_KEEP || adjust == ADJ_UP || adjust == ADJ_DOWN)

endmodule

bind pwm_speed_regulator_top psr_checker u_psr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.pwm_level   (pwm_level),
	.interval_us (interval_us),
	.window_end  (window_end),
	.speed_now   (speed_now),
	.adjust      (adjust)
);

`default_nettype wire
